// ----- rtl/lprb_pkg.sv -----
// Package for the light pulse ratio byte receiver.
// Holds the beat structs, configuration register indexes, reset values and class codes.
// No dependencies.
package lprb_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int TIME_W      = 32;
  localparam int DELTA_W     = 10;
  localparam int LIMIT_W     = 12;
  localparam int BYTE_W      = 8;
  localparam int RATIO_SHIFT = 10;
  localparam int PROD_W      = TIME_W + LIMIT_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_DELTA   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHORT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEUTRAL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE     = 3'd4;

  localparam logic [DELTA_W-1:0] DELTA_RST   = 10'd0;
  localparam logic [LIMIT_W-1:0] SHORT_RST   = 12'd307;
  localparam logic [LIMIT_W-1:0] ZERO_RST    = 12'd696;
  localparam logic [LIMIT_W-1:0] NEUTRAL_RST = 12'd737;
  localparam logic [LIMIT_W-1:0] ONE_RST     = 12'd1024;

  typedef enum logic [2:0] {
    CLS_SHORT   = 3'd0,
    CLS_ZERO    = 3'd1,
    CLS_NEUTRAL = 3'd2,
    CLS_ONE     = 3'd3,
    CLS_LONG    = 3'd4
  } bit_class_t;

  typedef struct packed {
    logic [TIME_W-1:0]   timestamp;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic              edge_fell;
    logic              bit_valid;
    bit_class_t        bit_class;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
  } out_item_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta_threshold;
    logic [LIMIT_W-1:0] short_limit;
    logic [LIMIT_W-1:0] zero_limit;
    logic [LIMIT_W-1:0] neutral_limit;
    logic [LIMIT_W-1:0] one_limit;
  } cfg_t;

  typedef struct packed {
    logic              fell;
    logic [TIME_W-1:0] first_len;
    logic [TIME_W-1:0] cycle_len;
  } edge_evt_t;

endpackage

// ----- rtl/lprb_cfg.sv -----
// Configuration register file of the light pulse ratio byte receiver.
// Depends on lprb_pkg for the register indexes, reset values and cfg_t.
module lprb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lprb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lprb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lprb_pkg::cfg_t                   cfg
);

  lprb_pkg::cfg_t cfg_r;
  lprb_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        lprb_pkg::CFG_DELTA:   cfg_nxt.delta_threshold = cfg_wdata[lprb_pkg::DELTA_W-1:0];
        lprb_pkg::CFG_SHORT:   cfg_nxt.short_limit     = cfg_wdata;
        lprb_pkg::CFG_ZERO:    cfg_nxt.zero_limit      = cfg_wdata;
        lprb_pkg::CFG_NEUTRAL: cfg_nxt.neutral_limit   = cfg_wdata;
        lprb_pkg::CFG_ONE:     cfg_nxt.one_limit       = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delta_threshold <= lprb_pkg::DELTA_RST;
      cfg_r.short_limit     <= lprb_pkg::SHORT_RST;
      cfg_r.zero_limit      <= lprb_pkg::ZERO_RST;
      cfg_r.neutral_limit   <= lprb_pkg::NEUTRAL_RST;
      cfg_r.one_limit       <= lprb_pkg::ONE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/lprb_edge.sv -----
// Edge detector stage: tracks the line level and cycle timing per input beat and
// registers one event per detected edge. Depends on lprb_pkg.
module lprb_edge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lprb_pkg::in_item_t               in_data,
  input  logic [lprb_pkg::DELTA_W-1:0]    delta_threshold,
  input  logic                             evt_take,
  output logic                             evt_valid,
  output lprb_pkg::edge_evt_t              evt
);

  logic [lprb_pkg::SAMPLE_W-1:0] edge_level_r, edge_level_nxt;
  logic                          is_high_r, is_high_nxt;
  logic [lprb_pkg::TIME_W-1:0]   cycle_start_r, cycle_start_nxt;
  logic [lprb_pkg::TIME_W-1:0]   first_len_r, first_len_nxt;
  logic                          evt_valid_r, evt_valid_nxt;
  lprb_pkg::edge_evt_t           evt_r, evt_nxt;

  logic                          accept;
  logic                          rise;
  logic                          fall;
  logic [lprb_pkg::TIME_W-1:0]   elapsed;

  assign in_stall = evt_valid_r && !evt_take;
  assign accept   = in_valid && !in_stall;
  assign elapsed  = in_data.timestamp - cycle_start_r;

  assign rise = !is_high_r && (in_data.sample > edge_level_r) &&
                ((in_data.sample - edge_level_r) > delta_threshold);
  assign fall = is_high_r && (edge_level_r > in_data.sample) &&
                ((edge_level_r - in_data.sample) > delta_threshold);

  always_comb begin
    edge_level_nxt  = edge_level_r;
    is_high_nxt     = is_high_r;
    cycle_start_nxt = cycle_start_r;
    first_len_nxt   = first_len_r;
    evt_valid_nxt   = evt_valid_r && !evt_take;
    evt_nxt         = evt_r;
    if (accept && (rise || fall)) begin
      edge_level_nxt    = in_data.sample;
      is_high_nxt       = rise;
      evt_valid_nxt     = 1'b1;
      evt_nxt.fell      = fall;
      evt_nxt.first_len = first_len_r;
      evt_nxt.cycle_len = elapsed;
      if (rise) begin
        first_len_nxt = elapsed;
      end else begin
        cycle_start_nxt = in_data.timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_level_r  <= '0;
      is_high_r     <= 1'b0;
      cycle_start_r <= '0;
      first_len_r   <= '0;
      evt_valid_r   <= 1'b0;
    end else begin
      edge_level_r  <= edge_level_nxt;
      is_high_r     <= is_high_nxt;
      cycle_start_r <= cycle_start_nxt;
      first_len_r   <= first_len_nxt;
      evt_valid_r   <= evt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    evt_r <= evt_nxt;
  end

  assign evt_valid = evt_valid_r;
  assign evt       = evt_r;

endmodule

// ----- rtl/lprb_class.sv -----
// Pulse classifier and byte assembler with the result register.
// Compares the first phase against the cycle length by cross-multiplication. Depends on lprb_pkg.
module lprb_class #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_valid,
  input  lprb_pkg::edge_evt_t  evt,
  output logic                 evt_take,
  input  lprb_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lprb_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(BITS_PER_BYTE + 1);

  logic [BITS_PER_BYTE-1:0]    shift_r, shift_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lprb_pkg::out_item_t         out_r, out_nxt;

  logic                        load;
  logic [lprb_pkg::PROD_W-1:0] phase_scaled;
  logic [lprb_pkg::PROD_W-1:0] prod_short, prod_zero, prod_neutral, prod_one;
  lprb_pkg::bit_class_t        cls;
  logic [BITS_PER_BYTE-1:0]    shift_new;
  logic [CNT_W-1:0]            count_new;

  assign evt_take = !out_valid_r || !out_stall;
  assign load     = evt_valid && evt_take;

  assign phase_scaled = lprb_pkg::PROD_W'(evt.first_len) << lprb_pkg::RATIO_SHIFT;
  assign prod_short   = cfg.short_limit   * evt.cycle_len;
  assign prod_zero    = cfg.zero_limit    * evt.cycle_len;
  assign prod_neutral = cfg.neutral_limit * evt.cycle_len;
  assign prod_one     = cfg.one_limit     * evt.cycle_len;

  always_comb begin
    if (phase_scaled < prod_short) begin
      cls = lprb_pkg::CLS_SHORT;
    end else if (phase_scaled < prod_zero) begin
      cls = lprb_pkg::CLS_ZERO;
    end else if (phase_scaled < prod_neutral) begin
      cls = lprb_pkg::CLS_NEUTRAL;
    end else if (phase_scaled < prod_one) begin
      cls = lprb_pkg::CLS_ONE;
    end else begin
      cls = lprb_pkg::CLS_LONG;
    end
  end

  assign shift_new = (shift_r << 1) | BITS_PER_BYTE'(cls == lprb_pkg::CLS_ONE);
  assign count_new = count_r + CNT_W'(1);

  always_comb begin
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt      = 1'b1;
      out_nxt.edge_fell  = evt.fell;
      out_nxt.bit_valid  = evt.fell;
      out_nxt.bit_class  = lprb_pkg::CLS_SHORT;
      out_nxt.byte_valid = 1'b0;
      out_nxt.byte_value = '0;
      if (evt.fell) begin
        out_nxt.bit_class = cls;
        if ((cls == lprb_pkg::CLS_ZERO) || (cls == lprb_pkg::CLS_ONE)) begin
          if (count_new == CNT_W'(BITS_PER_BYTE)) begin
            out_nxt.byte_valid = 1'b1;
            out_nxt.byte_value = lprb_pkg::BYTE_W'(shift_new);
            shift_nxt          = '0;
            count_nxt          = '0;
          end else begin
            shift_nxt = shift_new;
            count_nxt = count_new;
          end
        end else begin
          shift_nxt = '0;
          count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/light_pulse_ratio_byte_receiver_core.sv -----
// Top level of the light pulse ratio byte receiver.
// Instantiates lprb_cfg, lprb_edge and lprb_class; depends on lprb_pkg.

// The core takes one sample beat per clock cycle while the input is not
// stalled. A beat that causes an edge produces one result beat through the
// edge event register and then the result register. A beat without an edge
// produces nothing. The limiting unit is the classifier, which holds four
// 12 x 32 bit multipliers working in parallel on the registered edge event.
// The input stalls only when an edge event is held because a result still
// waits to be taken. Timestamp differences wrap modulo 2^32. The user
// must write configuration only while the core is idle; it is not enforced.
module light_pulse_ratio_byte_receiver_core #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lprb_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lprb_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [lprb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lprb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lprb_pkg::cfg_t      cfg;
  lprb_pkg::edge_evt_t evt;
  logic                evt_valid;
  logic                evt_take;

  lprb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lprb_edge u_edge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .delta_threshold (cfg.delta_threshold),
    .evt_take        (evt_take),
    .evt_valid       (evt_valid),
    .evt             (evt)
  );

  lprb_class #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_take  (evt_take),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/lprb_checker.sv -----
// Port checker for the light pulse ratio byte receiver, bound to the top level.
// Depends on lprb_pkg and light_pulse_ratio_byte_receiver_core.
module lprb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lprb_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed or vanished.");

  a_bit_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bit_valid == out_data.edge_fell)
    else $error("Bit report does not match the falling edge flag.");

  a_rise_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.edge_fell |->
      out_data.bit_class == lprb_pkg::CLS_SHORT && !out_data.byte_valid &&
      out_data.byte_value == '0)
    else $error("Rising edge beat carries class or byte data.");

  a_byte_data_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |->
      out_data.bit_class == lprb_pkg::CLS_ZERO || out_data.bit_class == lprb_pkg::CLS_ONE)
    else $error("Byte completed by a bit that is neither zero nor one.");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.byte_value == '0)
    else $error("Byte value present without a completed byte.");

endmodule

bind light_pulse_ratio_byte_receiver_core lprb_checker u_lprb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
